@@ sv/rtc_pkg.sv @@
// rtc_pkg: shared constants for the range table carve block.
// Item kind codes, result status codes, field widths and default sizes.
// No dependencies.
package rtc_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam int ADDR_W      = 32;
   localparam int KIND_W      = 2;
   localparam int SLOT_W      = 4;
   localparam int STATUS_W    = 2;
   localparam int RAM_W       = 2 * ADDR_W;

   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CARVE  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd2;

endpackage

@@ sv/range_table_carve.sv @@
// range_table_carve: table of free address ranges with load, search and carve.
// Depends on rtc_pkg, rtc_ram (base/length store) and rtc_free_find.
//
//  channel   | ports                                    | handshake
//  ----------+------------------------------------------+----------------------------
//  request   | req_kind req_slot req_keep req_address   | taken when start && !busy
//            | req_size                                 |
//  response  | rsp_status rsp_entry_index               | rsp_valid, one cycle, no
//            | rsp_entry_base rsp_entry_length          | backpressure
//
// A load or an unknown kind is done in the accept cycle; its response shows
// in the next cycle and busy never rises. A search or carve scans the RAM
// one slot per cycle through its single read port: issue_ff addresses the
// RAM, the data leaves its read register and is then checked. A search hit
// answers through the response registers, a carve first through the carve
// state. A split answers like any carve but then holds busy in the split
// state for its second write. A miss answers after the last slot's check.
// Reset clears the valid bits and the control state; the RAM needs no clear
// since no slot turns valid before it is written.
// The receiver cannot stall; every response is a single-cycle strobe.
module range_table_carve #(
   parameter int ENTRIES = rtc_pkg::ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [rtc_pkg::KIND_W-1:0]   req_kind,
   input  logic [rtc_pkg::SLOT_W-1:0]   req_slot,
   input  logic                         req_keep,
   input  logic [rtc_pkg::ADDR_W-1:0]   req_address,
   input  logic [rtc_pkg::ADDR_W-1:0]   req_size,
   output logic                         rsp_valid,
   output logic [rtc_pkg::STATUS_W-1:0] rsp_status,
   output logic [rtc_pkg::SLOT_W-1:0]   rsp_entry_index,
   output logic [rtc_pkg::ADDR_W-1:0]   rsp_entry_base,
   output logic [rtc_pkg::ADDR_W-1:0]   rsp_entry_length
);

   localparam int AW = $clog2(ENTRIES);
   localparam int DW = rtc_pkg::ADDR_W;
   localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_CARVE = 2'd2;
   localparam logic [1:0] S_SPLIT = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [rtc_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [DW-1:0]                addr_ff, addr_in;
   logic [DW-1:0]                size_ff, size_in;
   logic [DW:0]                  req_end_ff, req_end_in;
   logic [AW-1:0]                issue_ff, issue_in;
   logic [AW-1:0]                chk_idx_ff, chk_idx_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [AW-1:0]                hit_idx_ff, hit_idx_in;
   logic [DW-1:0]                hit_base_ff, hit_base_in;
   logic [DW-1:0]                hit_len_ff, hit_len_in;
   logic [DW:0]                  hit_end_ff, hit_end_in;
   logic [ENTRIES-1:0]           valid_ff, valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rtc_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [rtc_pkg::SLOT_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [DW-1:0]                rsp_base_ff, rsp_base_in;
   logic [DW-1:0]                rsp_len_ff, rsp_len_in;

   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [2*DW-1:0]              wr_data;
   logic [2*DW-1:0]              rd_data;
   logic                         free_found;
   logic [AW-1:0]                free_idx;

   logic                         accept;
   logic [DW-1:0]                ent_base, ent_len;
   logic [DW:0]                  ent_end;
   logic                         hit;
   logic [DW-1:0]                len_cut;

   rtc_ram #(
      .WIDTH (2 * DW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (issue_ff),
      .rd_data (rd_data)
   );

   rtc_free_find #(
      .ENTRIES (ENTRIES)
   ) u_free (
      .clock (clock),
      .valid (valid_ff),
      .found (free_found),
      .index (free_idx)
   );

   assign accept = start && (state_ff == S_IDLE);

   // slot whose read was issued in the previous cycle, checked against the request
   assign ent_base = rd_data[2*DW-1:DW];
   assign ent_len  = rd_data[DW-1:0];
   assign ent_end  = {1'b0, ent_base} + {1'b0, ent_len};
   assign hit      = chk_vld_ff && valid_ff[chk_idx_ff]
                     && (ent_base <= addr_ff) && (ent_end >= req_end_ff);
   assign len_cut  = hit_len_ff - size_ff;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      req_end_in    = req_end_ff;
      issue_in      = issue_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      hit_idx_in    = hit_idx_ff;
      hit_base_in   = hit_base_ff;
      hit_len_in    = hit_len_ff;
      hit_end_in    = hit_end_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_len_in    = rsp_len_ff;
      wr_en         = 1'b0;
      wr_addr       = hit_idx_ff;
      wr_data       = {hit_base_ff, len_cut};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in    = req_kind;
               addr_in    = req_address;
               size_in    = req_size;
               req_end_in = {1'b0, req_address} + {1'b0, req_size};
               issue_in   = '0;
               chk_vld_in = 1'b0;
               unique case (req_kind) inside
                  rtc_pkg::KIND_LOAD: begin
                     // load writes straight from the ports
                     rsp_valid_in = 1'b1;
                     rsp_index_in = req_slot;
                     if (int'(req_slot) < ENTRIES) begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(req_slot);
                        wr_data  = {req_address, req_size};
                        valid_in[AW'(req_slot)] = req_keep;
                        rsp_status_in = rtc_pkg::ST_DONE;
                        rsp_base_in   = req_address;
                        rsp_len_in    = req_size;
                     end else begin
                        rsp_status_in = rtc_pkg::ST_MISS;
                        rsp_base_in   = '0;
                        rsp_len_in    = '0;
                     end
                  end
                  rtc_pkg::KIND_SEARCH, rtc_pkg::KIND_CARVE: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     // unknown kind: answer with all zero
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = rtc_pkg::ST_DONE;
                     rsp_index_in  = '0;
                     rsp_base_in   = '0;
                     rsp_len_in    = '0;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // issue the next read, hold at the last slot
            issue_in   = (issue_ff == LAST) ? issue_ff : issue_ff + 1'b1;
            chk_idx_in = issue_ff;
            chk_vld_in = 1'b1;
            if (hit) begin
               if (kind_ff == rtc_pkg::KIND_SEARCH) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = rtc_pkg::ST_DONE;
                  rsp_index_in  = 4'(chk_idx_ff);
                  rsp_base_in   = ent_base;
                  rsp_len_in    = ent_len;
                  state_in      = S_IDLE;
               end else begin
                  hit_idx_in  = chk_idx_ff;
                  hit_base_in = ent_base;
                  hit_len_in  = ent_len;
                  hit_end_in  = ent_end;
                  state_in    = S_CARVE;
               end
            end else if (chk_vld_ff && (chk_idx_ff == LAST)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rtc_pkg::ST_MISS;
               rsp_index_in  = '0;
               rsp_base_in   = '0;
               rsp_len_in    = '0;
               state_in      = S_IDLE;
            end
         end

         S_CARVE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = rtc_pkg::ST_DONE;
            rsp_index_in  = 4'(hit_idx_ff);
            state_in      = S_IDLE;
            if ((addr_ff == hit_base_ff) && (size_ff == hit_len_ff)) begin
               // exact match: drop the entry
               valid_in[hit_idx_ff] = 1'b0;
               rsp_base_in = '0;
               rsp_len_in  = '0;
            end else if (addr_ff == hit_base_ff) begin
               // front trim
               wr_en       = 1'b1;
               wr_data     = {req_end_ff[DW-1:0], len_cut};
               rsp_base_in = req_end_ff[DW-1:0];
               rsp_len_in  = len_cut;
            end else if (req_end_ff == hit_end_ff) begin
               // back trim
               wr_en       = 1'b1;
               wr_data     = {hit_base_ff, len_cut};
               rsp_base_in = hit_base_ff;
               rsp_len_in  = len_cut;
            end else if (free_found) begin
               // split: lower part stays here, upper part next cycle
               wr_en       = 1'b1;
               wr_data     = {hit_base_ff, addr_ff - hit_base_ff};
               rsp_base_in = hit_base_ff;
               rsp_len_in  = addr_ff - hit_base_ff;
               state_in    = S_SPLIT;
            end else begin
               rsp_status_in = rtc_pkg::ST_NOFREE;
               rsp_base_in   = hit_base_ff;
               rsp_len_in    = hit_len_ff;
            end
         end

         S_SPLIT: begin
            wr_en              = 1'b1;
            wr_addr            = free_idx;
            wr_data            = {req_end_ff[DW-1:0], DW'(hit_end_ff - req_end_ff)};
            valid_in[free_idx] = 1'b1;
            state_in           = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         issue_ff     <= '0;
         chk_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         issue_ff     <= issue_in;
         chk_idx_ff   <= chk_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      req_end_ff    <= req_end_in;
      hit_idx_ff    <= hit_idx_in;
      hit_base_ff   <= hit_base_in;
      hit_len_ff    <= hit_len_in;
      hit_end_ff    <= hit_end_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_index  = rsp_index_ff;
   assign rsp_entry_base   = rsp_base_ff;
   assign rsp_entry_length = rsp_len_ff;

   // every accepted transaction either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither answered nor busy");

   // the upper half of a split lands in a slot that is still free
   a_split_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPLIT) |-> (free_found && !valid_ff[free_idx]))
      else $error("split target slot is not free");

   // the split target never overwrites the entry being carved
   a_split_other: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPLIT) |-> (free_idx != hit_idx_ff))
      else $error("split target equals carved slot");

endmodule

@@ sv/rtc_ram.sv @@
// rtc_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on rtc_pkg for default sizes.
module rtc_ram #(
   parameter int WIDTH = rtc_pkg::RAM_W,
   parameter int DEPTH = rtc_pkg::ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rtc_free_find.sv @@
// rtc_free_find: registered search for the lowest slot whose valid bit is clear.
// Depends on rtc_pkg for the default table size.
module rtc_free_find #(
   parameter int ENTRIES = rtc_pkg::ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic [ENTRIES-1:0]         valid,
   output logic                       found,
   output logic [$clog2(ENTRIES)-1:0] index
);

   localparam int AW = $clog2(ENTRIES);

   logic          found_in, found_ff;
   logic [AW-1:0] index_in, index_ff;

   // scan downward so the lowest free slot wins
   always_comb begin
      found_in = 1'b0;
      index_in = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid[i]) begin
            found_in = 1'b1;
            index_in = AW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      index_ff <= index_in;
   end

   assign found = found_ff;
   assign index = index_ff;

endmodule

@@ tb/tb_range_table_carve.sv @@
// tb_range_table_carve: self-checking testbench for range_table_carve.
// Drives load, search, carve and unknown-kind commands and predicts every response
// from its own copy of the range table. Depends on rtc_pkg and range_table_carve.
module tb_range_table_carve;

   localparam int N_SLOTS      = rtc_pkg::ENTRIES_DEF;
   localparam int ITEM_TARGET  = 1350;
   localparam int CYCLE_LIMIT  = 400000;
   // a miss scans every slot; the drain covers a full scan before closing the run
   localparam int DRAIN_CYCLES = 2 * N_SLOTS + 8;
   // kind code with no operation behind it; the block answers with all zeros
   localparam logic [rtc_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

   typedef struct packed {
      logic [rtc_pkg::KIND_W-1:0] kind;
      logic [rtc_pkg::SLOT_W-1:0] slot;
      logic                       keep;
      logic [rtc_pkg::ADDR_W-1:0] address;
      logic [rtc_pkg::ADDR_W-1:0] size;
   } range_cmd_type;

   typedef struct packed {
      logic [rtc_pkg::STATUS_W-1:0] status;
      logic [rtc_pkg::SLOT_W-1:0]   index;
      logic [rtc_pkg::ADDR_W-1:0]   base;
      logic [rtc_pkg::ADDR_W-1:0]   length;
   } range_rsp_type;

   logic                         clock   = 1'b0;
   logic                         reset   = 1'b1;
   logic                         start   = 1'b0;
   logic [rtc_pkg::KIND_W-1:0]   req_kind    = '0;
   logic [rtc_pkg::SLOT_W-1:0]   req_slot    = '0;
   logic                         req_keep    = 1'b0;
   logic [rtc_pkg::ADDR_W-1:0]   req_address = '0;
   logic [rtc_pkg::ADDR_W-1:0]   req_size    = '0;
   logic                         busy;
   logic                         rsp_valid;
   logic [rtc_pkg::STATUS_W-1:0] rsp_status;
   logic [rtc_pkg::SLOT_W-1:0]   rsp_entry_index;
   logic [rtc_pkg::ADDR_W-1:0]   rsp_entry_base;
   logic [rtc_pkg::ADDR_W-1:0]   rsp_entry_length;

   range_table_carve i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_slot         (req_slot),
      .req_keep         (req_keep),
      .req_address      (req_address),
      .req_size         (req_size),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_entry_base   (rsp_entry_base),
      .rsp_entry_length (rsp_entry_length)
   );

   always #4 clock = ~clock;

   // Commands waiting to be driven, and the responses predicted for accepted ones.
   range_cmd_type cmd_backlog[$];
   range_rsp_type rsp_expected[$];

   // Predicted free-range table.
   logic                       free_valid[N_SLOTS];
   logic [rtc_pkg::ADDR_W-1:0] free_base[N_SLOTS];
   logic [rtc_pkg::ADDR_W-1:0] free_len[N_SLOTS];

   // Ranges last queued per slot by queue_load; used only to aim stimulus at loaded ranges.
   logic [rtc_pkg::ADDR_W-1:0] aim_base[N_SLOTS];
   logic [rtc_pkg::ADDR_W-1:0] aim_len[N_SLOTS];

   range_cmd_type cur_cmd;
   logic          cur_live = 1'b0;
   int            items_taken = 0;
   int            total_items = 1;
   int            gap_pct;
   int            cycle_count = 0;
   int            rsp_checked = 0;
   int            mismatch_count = 0;
   int            n_load = 0, n_search = 0, n_carve = 0;
   int            n_split = 0, n_nofree = 0, n_miss = 0;

   initial begin
      for (int s = 0; s < N_SLOTS; s++) begin
         free_valid[s] = 1'b0;
         free_base[s]  = '0;
         free_len[s]   = '0;
         aim_base[s]   = '0;
         aim_len[s]    = '0;
      end
   end

   // Apply one accepted transaction to the predicted table; return its response.
   function automatic range_rsp_type range_apply(input range_cmd_type cmd);
      range_rsp_type              r;
      int                         hit;
      int                         spare;
      logic [rtc_pkg::ADDR_W:0]   req_end;
      logic [rtc_pkg::ADDR_W:0]   ent_end;
      logic [rtc_pkg::ADDR_W:0]   rest;
      logic [rtc_pkg::ADDR_W-1:0] b;
      logic [rtc_pkg::ADDR_W-1:0] l;
      r       = '0;
      hit     = -1;
      spare   = -1;
      req_end = {1'b0, cmd.address} + {1'b0, cmd.size};
      if (cmd.kind == rtc_pkg::KIND_LOAD) begin
         n_load++;
         free_valid[cmd.slot] = cmd.keep;
         free_base[cmd.slot]  = cmd.address;
         free_len[cmd.slot]   = cmd.size;
         r.status = rtc_pkg::ST_DONE;
         r.index  = cmd.slot;
         r.base   = cmd.address;
         r.length = cmd.size;
         return r;
      end
      if (cmd.kind != rtc_pkg::KIND_SEARCH && cmd.kind != rtc_pkg::KIND_CARVE)
         return r;
      if (cmd.kind == rtc_pkg::KIND_SEARCH)
         n_search++;
      else
         n_carve++;
      // first valid slot, in slot order, whose 33-bit span holds the request
      for (int i = 0; i < N_SLOTS; i++) begin
         ent_end = {1'b0, free_base[i]} + {1'b0, free_len[i]};
         if (hit < 0 && free_valid[i] && free_base[i] <= cmd.address && ent_end >= req_end)
            hit = i;
      end
      if (hit < 0) begin
         n_miss++;
         r.status = rtc_pkg::ST_MISS;
         return r;
      end
      b       = free_base[hit];
      l       = free_len[hit];
      ent_end = {1'b0, b} + {1'b0, l};
      r.index = rtc_pkg::SLOT_W'(hit);
      if (cmd.kind == rtc_pkg::KIND_SEARCH) begin
         r.status = rtc_pkg::ST_DONE;
         r.base   = b;
         r.length = l;
         return r;
      end
      if (cmd.address == b && cmd.size == l) begin
         // exact match: drop the entry
         free_valid[hit] = 1'b0;
         r.status = rtc_pkg::ST_DONE;
         return r;
      end
      if (cmd.address == b) begin
         free_base[hit] = req_end[rtc_pkg::ADDR_W-1:0];
         free_len[hit]  = l - cmd.size;
      end else if (req_end == ent_end) begin
         free_len[hit] = l - cmd.size;
      end else begin
         for (int j = 0; j < N_SLOTS; j++)
            if (spare < 0 && !free_valid[j])
               spare = j;
         if (spare < 0) begin
            n_nofree++;
            r.status = rtc_pkg::ST_NOFREE;
            r.base   = b;
            r.length = l;
            return r;
         end
         n_split++;
         rest               = ent_end - req_end;
         free_valid[spare]  = 1'b1;
         free_base[spare]   = req_end[rtc_pkg::ADDR_W-1:0];
         free_len[spare]    = rest[rtc_pkg::ADDR_W-1:0];
         free_len[hit]      = cmd.address - b;
      end
      r.status = rtc_pkg::ST_DONE;
      r.base   = free_base[hit];
      r.length = free_len[hit];
      return r;
   endfunction

   task automatic queue_cmd(input logic [rtc_pkg::KIND_W-1:0] kind, input int slot,
                            input logic keep, input logic [rtc_pkg::ADDR_W-1:0] address,
                            input logic [rtc_pkg::ADDR_W-1:0] size);
      range_cmd_type c;
      c.kind    = kind;
      c.slot    = rtc_pkg::SLOT_W'(slot);
      c.keep    = keep;
      c.address = address;
      c.size    = size;
      cmd_backlog.push_back(c);
   endtask

   // Load a slot with a fresh range, mostly short, now and then empty, huge,
   // near the top of the address space or overlapping another slot.
   task automatic queue_load(input int slot, input logic keep);
      int                         pick;
      logic [rtc_pkg::ADDR_W-1:0] b;
      logic [rtc_pkg::ADDR_W-1:0] l;
      pick = $urandom_range(0, 19);
      b    = $urandom();
      l    = $urandom_range(2, 4096);
      case (pick)
         0: l = '0;
         1: l = $urandom();
         2: b = 32'hFFFF_F000 | $urandom_range(0, 4095);
         3: b = aim_base[$urandom_range(0, N_SLOTS - 1)] + $urandom_range(0, 64);
         default: ;
      endcase
      aim_base[slot] = b;
      aim_len[slot]  = l;
      queue_cmd(rtc_pkg::KIND_LOAD, slot, keep, b, l);
   endtask

   // Search or carve a piece of range (b, l): exact, front, back, inside,
   // zero length, overhanging, or anywhere at all.
   task automatic queue_aimed(input logic [rtc_pkg::KIND_W-1:0] kind,
                              input logic [rtc_pkg::ADDR_W-1:0] b,
                              input logic [rtc_pkg::ADDR_W-1:0] l);
      logic [rtc_pkg::ADDR_W-1:0] off;
      logic [rtc_pkg::ADDR_W-1:0] sz;
      off = '0;
      sz  = l;
      case ($urandom_range(0, 7))
         0: ;
         1: sz = (l == 0) ? '0 : $urandom_range(0, l - 1);
         2: begin
            sz  = (l == 0) ? '0 : $urandom_range(0, l - 1);
            off = l - sz;
         end
         3, 4: begin
            if (l >= 2) begin
               off = $urandom_range(1, l - 1);
               sz  = $urandom_range(0, l - off - 1);
            end
         end
         5: begin
            off = (l == 0) ? '0 : $urandom_range(0, l);
            sz  = '0;
         end
         6: sz = l + 1;
         default: begin
            queue_cmd(kind, $urandom_range(0, N_SLOTS - 1), 1'($urandom_range(0, 1)),
                      $urandom(), $urandom());
            return;
         end
      endcase
      queue_cmd(kind, $urandom_range(0, N_SLOTS - 1), 1'($urandom_range(0, 1)),
                b + off, sz);
   endtask

   // Stimulus: directed opening, then random episodes of loads followed by
   // searches and carves aimed at the loaded ranges.
   initial begin
      int mode;
      int t;
      int r;
      // write every slot once so no scan ever reads an unwritten entry
      queue_cmd(rtc_pkg::KIND_LOAD, 0, 1'b1, 32'h0000_1000, 32'h0000_0100);
      for (int s = 1; s < N_SLOTS - 1; s++)
         queue_cmd(rtc_pkg::KIND_LOAD, s, 1'b0, $urandom(), $urandom());
      queue_cmd(rtc_pkg::KIND_LOAD, N_SLOTS - 1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_cmd(rtc_pkg::KIND_SEARCH, 0, 1'b0, 32'h0000_1010, 32'h0000_0010);  // hit inside
      queue_cmd(rtc_pkg::KIND_SEARCH, 0, 1'b0, 32'h0000_10F0, 32'h0000_0020);  // runs off end
      queue_cmd(rtc_pkg::KIND_SEARCH, 0, 1'b0, 32'h0000_1000, 32'h0000_0100);  // whole entry
      queue_cmd(rtc_pkg::KIND_CARVE, 0, 1'b0, 32'h0000_1000, 32'h0000_0010);   // trim front
      queue_cmd(rtc_pkg::KIND_CARVE, 0, 1'b0, 32'h0000_10F0, 32'h0000_0010);   // trim back
      queue_cmd(rtc_pkg::KIND_CARVE, 0, 1'b0, 32'h0000_1080, 32'h0000_0010);   // split
      queue_cmd(rtc_pkg::KIND_CARVE, 0, 1'b0, 32'h0000_1090, 32'h0000_0050);   // trim front of upper part
      queue_cmd(rtc_pkg::KIND_CARVE, 0, 1'b0, 32'h0000_1010, 32'h0000_0000);   // zero at base
      queue_cmd(rtc_pkg::KIND_CARVE, 0, 1'b0, 32'h0000_1020, 32'h0000_0000);   // zero inside
      queue_cmd(rtc_pkg::KIND_LOAD, 2, 1'b1, 32'hFFFF_FFF0, 32'hFFFF_FFFF);    // past top
      queue_cmd(rtc_pkg::KIND_SEARCH, 0, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
      queue_cmd(rtc_pkg::KIND_CARVE, 0, 1'b0, 32'hFFFF_FFF0, 32'h0000_0020);   // base wraps
      queue_cmd(KIND_NONE, 15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_cmd(rtc_pkg::KIND_CARVE, 0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_cmd(rtc_pkg::KIND_LOAD, 2, 1'b0, 32'h0000_0000, 32'h0000_0000);

      while (cmd_backlog.size() < ITEM_TARGET) begin
         mode = $urandom_range(0, 7);
         if (mode == 0) begin
            // fill every slot so splits run out of room
            for (int s = 0; s < N_SLOTS; s++)
               queue_load(s, 1'b1);
         end else if (mode == 1) begin
            // release most slots
            for (int s = 0; s < N_SLOTS; s++)
               if ($urandom_range(0, 3) != 0)
                  queue_cmd(rtc_pkg::KIND_LOAD, s, 1'b0, $urandom(), $urandom());
         end else begin
            repeat ($urandom_range(1, 4))
               queue_load($urandom_range(0, N_SLOTS - 1), $urandom_range(0, 9) != 0);
         end
         repeat ($urandom_range(4, 16)) begin
            r = $urandom_range(0, 19);
            t = $urandom_range(0, N_SLOTS - 1);
            if (r == 0)
               queue_cmd(KIND_NONE, t, 1'($urandom_range(0, 1)), $urandom(), $urandom());
            else if (r == 1)
               queue_load(t, 1'($urandom_range(0, 1)));
            else if (r < 8)
               queue_aimed(rtc_pkg::KIND_SEARCH, aim_base[t], aim_len[t]);
            else
               queue_aimed(rtc_pkg::KIND_CARVE, aim_base[t], aim_len[t]);
         end
      end
      total_items = cmd_backlog.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // hold until every command is taken and every response has arrived
      wait (items_taken == total_items && !cur_live);
      while (rsp_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d responses: %0d loads, %0d searches, %0d carves", rsp_checked,
               n_load, n_search, n_carve);
      $display("carves split %0d entries, hit a full table %0d times; %0d misses",
               n_split, n_nofree, n_miss);
      if (mismatch_count == 0 && rsp_expected.size() == 0) begin
         $display("range_table_carve test passed");
      end else begin
         $display("range_table_carve test failed");
      end
      $finish;
   end

   // Driver: a transaction is taken at an edge with start high and busy low.
   // Predict at that edge, then pick up the next command unless the sender
   // idles. The idle rate changes per quarter of the run: none, 45 %, none, 28 %.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            rsp_expected.push_back(range_apply(cur_cmd));
            cur_live = 1'b0;
         end
         case ((items_taken * 4) / total_items)
            1: gap_pct = 45;
            3: gap_pct = 28;
            default: gap_pct = 0;
         endcase
         if (!cur_live && cmd_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
            cur_cmd  = cmd_backlog.pop_front();
            cur_live = 1'b1;
            items_taken++;
         end
         // hold start and the fields steady until the block takes them
         start       <= cur_live;
         req_kind    <= cur_cmd.kind;
         req_slot    <= cur_cmd.slot;
         req_keep    <= cur_cmd.keep;
         req_address <= cur_cmd.address;
         req_size    <= cur_cmd.size;
      end
   end

   // Monitor: each strobe carries one response; match it against the oldest prediction.
   always @(posedge clock) begin
      range_rsp_type want;
      if (!reset && rsp_valid) begin
         rsp_checked++;
         if (rsp_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: st=%0d idx=%0d base=%h len=%h", rsp_status,
                        rsp_entry_index, rsp_entry_base, rsp_entry_length);
         end else begin
            want = rsp_expected.pop_front();
            if (want.status !== rsp_status || want.index !== rsp_entry_index ||
                want.base !== rsp_entry_base || want.length !== rsp_entry_length) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch on response %0d: expected st=%0d idx=%0d base=%h len=%h",
                           rsp_checked, want.status, want.index, want.base, want.length);
                  $display("   got st=%0d idx=%0d base=%h len=%h", rsp_status,
                           rsp_entry_index, rsp_entry_base, rsp_entry_length);
               end
            end
         end
      end
   end

   // Watchdog: stop a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses pending", cycle_count,
               rsp_expected.size());
      $display("range_table_carve test failed");
      $finish;
   end

endmodule
